### hdl/ptmtf_pkg.sv
// shared types and codes for the peer table with move-to-front ordering
// no dependencies; imported by every module of the block
`default_nettype none

package ptmtf_pkg;

  localparam int TableDepthDef = 16;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // radio action codes
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_REPLACE = 3'd2;
  localparam logic [2:0] ACT_MODIFY  = 3'd3;
  localparam logic [2:0] ACT_DELETE  = 3'd4;

  // one table slot
  typedef struct packed {
    logic [7:0]  id;
    logic [47:0] mac;
    logic [3:0]  channel;
    logic [7:0]  ntype;
    logic [31:0] seen;
  } entry_t;

  // one result item
  typedef struct packed {
    logic        status;
    logic [47:0] peer_mac;
    logic [3:0]  peer_channel;
    logic [7:0]  peer_type;
    logic [31:0] peer_seen;
    logic [2:0]  radio_action;
    logic        evicted;
    logic [47:0] evicted_mac;
    logic [4:0]  entry_count;
  } res_t;

endpackage

`default_nettype wire

### hdl/peer_table_move_to_front_top.sv
// top level of the peer table with move-to-front ordering and lru eviction
// uses ptmtf_pkg, ptmtf_mem and ptmtf_ctrl
`default_nettype none

// Peer table of up to TABLE_DEPTH entries kept in order of latest add or
// update, slot 0 being the newest. Each input transfer is one request
// (add or update, remove, look up) and produces exactly one result
// transfer. The slots live in a single memory with a registered read; a
// request first scans slots from the front, one read per cycle, until the
// node id matches, then moves entries one slot per cycle through the same
// memory to open the front or close the gap. An add then writes the new
// entry to the front, and the result is handed on before the sequencer
// returns to idle. A lookup skips the moves.
// One request is worked on at a time; the result sits in an output
// register, so the next request is taken while the previous result is
// still stalled. No clearing pass is needed after reset.

module peer_table_move_to_front_top
  import ptmtf_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  node_id_i,
  input  wire logic [47:0] mac_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [7:0]  node_type_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [47:0]      peer_mac_o,
  output logic [3:0]       peer_channel_o,
  output logic [7:0]       peer_type_o,
  output logic [31:0]      peer_seen_o,
  output logic [2:0]       radio_action_o,
  output logic             evicted_o,
  output logic [47:0]      evicted_mac_o,
  output logic [4:0]       entry_count_o
);

  localparam int Aw = $clog2(TABLE_DEPTH);
  localparam int Cw = $clog2(TABLE_DEPTH + 1);

  logic          ctrl_idle;
  logic          in_accept;
  entry_t        in_req;
  logic          rd_en;
  logic [Aw-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [Aw-1:0] wr_addr;
  entry_t        wr_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  // output register
  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  // a new request is taken whenever the sequencer is free
  assign in_stall_o = !ctrl_idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_req.id      = node_id_i;
  assign in_req.mac     = mac_i;
  assign in_req.channel = channel_i;
  assign in_req.ntype   = node_type_i;
  assign in_req.seen    = now_ms_i;

  ptmtf_mem #(
    .Depth (TABLE_DEPTH),
    .Aw    (Aw)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ptmtf_ctrl #(
    .Depth (TABLE_DEPTH),
    .Aw    (Aw),
    .Cw    (Cw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .idle_o      (ctrl_idle),
    .in_accept_i (in_accept),
    .in_kind_i   (kind_i),
    .in_req_i    (in_req),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // the register takes a new result when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign peer_mac_o     = out_q.peer_mac;
  assign peer_channel_o = out_q.peer_channel;
  assign peer_type_o    = out_q.peer_type;
  assign peer_seen_o    = out_q.peer_seen;
  assign radio_action_o = out_q.radio_action;
  assign evicted_o      = out_q.evicted;
  assign evicted_mac_o  = out_q.evicted_mac;
  assign entry_count_o  = out_q.entry_count;

endmodule

`default_nettype wire

### hdl/ptmtf_mem.sv
// slot memory of the peer table: one write port, one read port, registered read
// uses entry_t from ptmtf_pkg
`default_nettype none

module ptmtf_mem
  import ptmtf_pkg::*;
#(
  parameter int Depth = TableDepthDef,
  parameter int Aw    = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [Aw-1:0] rd_addr_i,
  output entry_t             rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [Aw-1:0] wr_addr_i,
  input  wire entry_t        wr_data_i
);

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/ptmtf_ctrl.sv
// sequencer of the peer table: scans slots, shifts them through the memory
// and builds the result; uses types and codes from ptmtf_pkg, drives ptmtf_mem
`default_nettype none

module ptmtf_ctrl
  import ptmtf_pkg::*;
#(
  parameter int Depth = TableDepthDef,
  parameter int Aw    = $clog2(Depth),
  parameter int Cw    = $clog2(Depth + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output logic               idle_o,
  input  wire logic          in_accept_i,
  input  wire logic [1:0]    in_kind_i,
  input  wire entry_t        in_req_i,
  output logic               rd_en_o,
  output logic [Aw-1:0]      rd_addr_o,
  input  wire entry_t        rd_data_i,
  output logic               wr_en_o,
  output logic [Aw-1:0]      wr_addr_o,
  output entry_t             wr_data_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output res_t               res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [Cw-1:0] fill_q, fill_d;
  logic [1:0]    kind_q, kind_d;
  entry_t        req_q, req_d;
  res_t          res_q, res_d;
  logic [Cw-1:0] scan_idx_q, scan_idx_d;
  logic          chk_valid_q, chk_valid_d;
  logic [Aw-1:0] chk_addr_q, chk_addr_d;
  logic [47:0]   evcap_q, evcap_d;
  logic [Cw-1:0] sh_rd_q, sh_rd_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          up_q, up_d;
  logic          pend_q, pend_d;
  logic [Cw-1:0] pend_wa_q, pend_wa_d;

  logic          hit;
  logic [Cw-1:0] slot;
  logic [Cw-1:0] pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      chk_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      chk_valid_q <= chk_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    req_q      <= req_d;
    res_q      <= res_d;
    scan_idx_q <= scan_idx_d;
    chk_addr_q <= chk_addr_d;
    evcap_q    <= evcap_d;
    sh_rd_q    <= sh_rd_d;
    cnt_q      <= cnt_d;
    up_q       <= up_d;
    pend_wa_q  <= pend_wa_d;
  end

  assign hit  = chk_valid_q && (rd_data_i.id == req_q.id);
  assign slot = Cw'(chk_addr_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    kind_d      = kind_q;
    req_d       = req_q;
    res_d       = res_q;
    scan_idx_d  = scan_idx_q;
    chk_valid_d = chk_valid_q;
    chk_addr_d  = chk_addr_q;
    evcap_d     = evcap_q;
    sh_rd_d     = sh_rd_q;
    cnt_d       = cnt_q;
    up_d        = up_q;
    pend_d      = pend_q;
    pend_wa_d   = pend_wa_q;
    pos         = fill_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;
    wr_en_o     = 1'b0;
    wr_addr_o   = '0;
    wr_data_o   = rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (in_accept_i) begin
          kind_d      = in_kind_i;
          req_d       = in_req_i;
          res_d       = '0;
          scan_idx_d  = '0;
          chk_valid_d = 1'b0;
          if (in_kind_i == KIND_ADD || in_kind_i == KIND_REMOVE ||
              in_kind_i == KIND_LOOKUP) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        chk_valid_d = 1'b0;
        // keep the last slot's mac in case the add must evict it
        if (chk_valid_q && chk_addr_q == Aw'(Depth - 1)) begin
          evcap_d = rd_data_i.mac;
        end
        if (hit) begin
          // first match from the front
          if (kind_q == KIND_ADD) begin
            res_d.peer_mac     = req_q.mac;
            res_d.peer_channel = req_q.channel;
            res_d.peer_type    = req_q.ntype;
            res_d.peer_seen    = req_q.seen;
            if (rd_data_i.mac != req_q.mac) begin
              res_d.radio_action = ACT_REPLACE;
            end else if (rd_data_i.channel != req_q.channel) begin
              res_d.radio_action = ACT_MODIFY;
            end else begin
              res_d.radio_action = ACT_NONE;
            end
            sh_rd_d = slot - Cw'(1);
            cnt_d   = slot;
            up_d    = 1'b1;
            state_d = S_SHIFT;
          end else begin
            res_d.peer_mac     = rd_data_i.mac;
            res_d.peer_channel = rd_data_i.channel;
            res_d.peer_type    = rd_data_i.ntype;
            res_d.peer_seen    = rd_data_i.seen;
            if (kind_q == KIND_REMOVE) begin
              res_d.radio_action = ACT_DELETE;
              sh_rd_d = slot + Cw'(1);
              cnt_d   = fill_q - Cw'(1) - slot;
              up_d    = 1'b0;
              fill_d  = fill_q - Cw'(1);
              state_d = S_SHIFT;
            end else begin
              state_d = S_DONE;
            end
          end
        end else if (!chk_valid_q && scan_idx_q >= fill_q) begin
          // whole table scanned, no match
          if (kind_q == KIND_ADD) begin
            res_d.peer_mac     = req_q.mac;
            res_d.peer_channel = req_q.channel;
            res_d.peer_type    = req_q.ntype;
            res_d.peer_seen    = req_q.seen;
            res_d.radio_action = ACT_ADD;
            if (fill_q == Cw'(Depth)) begin
              res_d.evicted     = 1'b1;
              res_d.evicted_mac = evcap_q;
              pos = Cw'(Depth - 1);
            end else begin
              pos    = fill_q;
              fill_d = fill_q + Cw'(1);
            end
            sh_rd_d = pos - Cw'(1);
            cnt_d   = pos;
            up_d    = 1'b1;
            state_d = S_SHIFT;
          end else begin
            res_d.status = 1'b1;
            state_d      = S_DONE;
          end
        end else if (scan_idx_q < fill_q) begin
          rd_en_o     = 1'b1;
          rd_addr_o   = scan_idx_q[Aw-1:0];
          chk_valid_d = 1'b1;
          chk_addr_d  = scan_idx_q[Aw-1:0];
          scan_idx_d  = scan_idx_q + Cw'(1);
        end
      end

      S_SHIFT: begin
        // write back the slot read last cycle one place further on
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = pend_wa_q[Aw-1:0];
          wr_data_o = rd_data_i;
        end
        if (cnt_q != '0) begin
          rd_en_o   = 1'b1;
          rd_addr_o = sh_rd_q[Aw-1:0];
          pend_d    = 1'b1;
          pend_wa_d = up_q ? sh_rd_q + Cw'(1) : sh_rd_q - Cw'(1);
          sh_rd_d   = up_q ? sh_rd_q - Cw'(1) : sh_rd_q + Cw'(1);
          cnt_d     = cnt_q - Cw'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = up_q ? S_FRONT : S_DONE;
          end
        end
      end

      S_FRONT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = req_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o             = res_q;
    res_o.entry_count = 5'(fill_q);
  end

endmodule

`default_nettype wire
